>>> design/bsd_pkg.sv
package bsd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_INVALID = 2'd1;
  localparam logic [1:0] ERR_AFTER_PAD = 2'd2;

  typedef enum logic [1:0] {
    CLS_IGNORE = 2'd0,
    CLS_PAD    = 2'd1,
    CLS_DATA   = 2'd2,
    CLS_BAD    = 2'd3
  } char_cls_t;

  typedef struct packed {
    char_cls_t  cls;
    logic [5:0] sextet;
    logic       eot;
  } q_entry_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // valid flag in bit 6, sextet in bits 5:0
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

>>> design/bsd_if.sv
interface bsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_text;
  modport source (output valid, output char_in, output end_of_text, input ready);
  modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

interface bsd_out_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] data_byte;
  logic [1:0] error_code;
  logic       text_done;
  modport source (output valid, output has_byte, output data_byte, output error_code,
                  output text_done, input ready);
  modport sink (input valid, input has_byte, input data_byte, input error_code,
                input text_done, output ready);
endinterface

interface bsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] skip_leading;
  modport source (output valid, output skip_leading, input ready);
  modport sink (input valid, input skip_leading, output ready);
endinterface

>>> design/bsd_front.sv
module bsd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        char_in,
  input  logic              end_of_text,
  input  logic [15:0]       skip_leading,
  input  logic              q_full,
  output logic              q_push,
  output bsd_pkg::q_entry_t q_wdata
);
  import bsd_pkg::*;

  logic [15:0] skip_cnt_r, skip_cnt_nxt;
  logic        skipping;
  logic [6:0]  sx;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign skipping = skip_cnt_r < skip_leading;
  assign sx       = sextet_of(char_in);

  always_comb begin
    q_wdata.eot    = end_of_text;
    q_wdata.sextet = sx[5:0];
    if (skipping || is_blank(char_in)) begin
      q_wdata.cls = CLS_IGNORE;
    end else if (char_in == PAD_CHAR) begin
      q_wdata.cls = CLS_PAD;
    end else if (sx[6]) begin
      q_wdata.cls = CLS_DATA;
    end else begin
      q_wdata.cls = CLS_BAD;
    end
  end

  always_comb begin
    skip_cnt_nxt = skip_cnt_r;
    if (q_push) begin
      if (end_of_text) begin
        skip_cnt_nxt = '0;
      end else if (skipping) begin
        skip_cnt_nxt = skip_cnt_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_cnt_r <= '0;
    end else begin
      skip_cnt_r <= skip_cnt_nxt;
    end
  end

endmodule

>>> design/bsd_queue.sv
module bsd_queue #(
  parameter int unsigned DEPTH = bsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bsd_pkg::q_entry_t wdata,
  input  logic              pop,
  output bsd_pkg::q_entry_t rdata,
  output logic              full,
  output logic              empty
);
  import bsd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [AW-1:0]   wptr_r, rptr_r;
  logic [CW-1:0]   count_r;

  assign full  = count_r == CW'(DEPTH);
  assign empty = count_r == '0;
  assign rdata = mem_r[rptr_r];

  function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= inc_ptr(wptr_r);
      end
      if (pop) begin
        rptr_r <= inc_ptr(rptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count out of range");

endmodule

>>> design/bsd_back.sv
module bsd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  bsd_pkg::q_entry_t q_rdata,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              has_byte,
  output logic [7:0]        data_byte,
  output logic [1:0]        error_code,
  output logic              text_done
);
  import bsd_pkg::*;

  logic [5:0]  res_bits_r, res_bits_nxt;
  logic [2:0]  res_cnt_r, res_cnt_nxt;
  logic        pad_r, pad_nxt;
  logic        err_r, err_nxt;
  logic        out_valid_r;
  logic        out_has_r;
  logic [7:0]  out_byte_r;
  logic [1:0]  out_err_r;
  logic        out_done_r;

  logic        has;
  logic [7:0]  byte_val;
  logic [1:0]  err_code;
  logic [11:0] acc;
  logic [3:0]  total;
  logic [2:0]  sh;
  logic [11:0] mask;
  logic [11:0] shifted;
  logic        emit;

  assign q_pop = !q_empty && (!out_valid_r || out_ready);

  always_comb begin
    res_bits_nxt = res_bits_r;
    res_cnt_nxt  = res_cnt_r;
    pad_nxt      = pad_r;
    err_nxt      = err_r;
    has          = 1'b0;
    byte_val     = 8'd0;
    err_code     = ERR_NONE;
    acc          = {res_bits_r, q_rdata.sextet};
    total        = {1'b0, res_cnt_r} + 4'd6;
    sh           = 3'(total - 4'd8);
    shifted      = acc >> sh;
    mask         = (12'd1 << sh) - 12'd1;
    if (q_rdata.cls == CLS_IGNORE || err_r) begin
      err_nxt = err_r;
    end else if (pad_r) begin
      if (q_rdata.cls != CLS_PAD) begin
        err_code = ERR_AFTER_PAD;
        err_nxt  = 1'b1;
      end
    end else begin
      unique case (q_rdata.cls)
        CLS_PAD: begin
          pad_nxt = 1'b1;
        end
        CLS_BAD: begin
          err_code = ERR_INVALID;
          err_nxt  = 1'b1;
        end
        CLS_DATA: begin
          if (total >= 4'd8) begin
            has          = 1'b1;
            byte_val     = shifted[7:0];
            res_bits_nxt = 6'(acc & mask);
            res_cnt_nxt  = sh;
          end else begin
            res_bits_nxt = acc[5:0];
            res_cnt_nxt  = total[2:0];
          end
        end
        default: begin
          err_nxt = err_r;
        end
      endcase
    end
    if (q_rdata.eot) begin
      res_bits_nxt = '0;
      res_cnt_nxt  = '0;
      pad_nxt      = 1'b0;
      err_nxt      = 1'b0;
    end
  end

  assign emit = q_pop && (has || err_code != ERR_NONE || q_rdata.eot);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_bits_r  <= '0;
      res_cnt_r   <= '0;
      pad_r       <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        res_bits_r <= res_bits_nxt;
        res_cnt_r  <= res_cnt_nxt;
        pad_r      <= pad_nxt;
        err_r      <= err_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_has_r  <= has;
      out_byte_r <= byte_val;
      out_err_r  <= err_code;
      out_done_r <= q_rdata.eot;
    end
  end

  assign out_valid  = out_valid_r;
  assign has_byte   = out_has_r;
  assign data_byte  = out_byte_r;
  assign error_code = out_err_r;
  assign text_done  = out_done_r;

  a_byte_or_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r != ERR_NONE |-> !out_has_r)
    else $error("byte and error in one beat");
  a_res_cnt_even: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r[0] == 1'b0) else $error("odd residual count");
  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_rdata.eot |=> res_cnt_r == '0 && !pad_r && !err_r)
    else $error("state not cleared after end of text");
  a_no_byte_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && err_r |-> !has) else $error("byte decoded while error latched");

endmodule

>>> design/base64_stream_decoder.sv
// Base64 stream decoder.
// in_ch: one character beat (char_in, end_of_text) per cycle on valid/ready.
// out_ch: one result beat per character that completes a byte, detects an
//   error or carries end_of_text (text_done set); others give no beat.
// cfg_ch: writes skip_leading, the number of leading characters of each
//   text that are dropped; always ready, takes effect on the next character
//   beat, also within a text; write only while no beat is in flight.
// Throughput: one character per cycle while out_ch is ready. The front
//   classifies and counts skipped characters, a small queue (QUEUE_DEPTH
//   entries) feeds the back end, which holds the residual bits and writes
//   the output register.
// Path: each input beat is written into the queue, and its result beat
//   into the output register.
// Reset: rst_n synchronous; clears decode state, queue and skip_leading.
// Stall: with a beat held and out_ch.ready low, the output register holds,
//   the back end stops draining and in_ch.ready falls when the queue fills.
module base64_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = bsd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bsd_in_if.sink    in_ch,
  bsd_out_if.source out_ch,
  bsd_cfg_if.sink   cfg_ch
);
  import bsd_pkg::*;

  logic [15:0] skip_leading_r;
  logic        q_full, q_empty, q_push, q_pop;
  q_entry_t    q_wdata, q_rdata;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_leading_r <= '0;
    end else if (cfg_ch.valid) begin
      skip_leading_r <= cfg_ch.skip_leading;
    end
  end

  bsd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .char_in      (in_ch.char_in),
    .end_of_text  (in_ch.end_of_text),
    .skip_leading (skip_leading_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  bsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  bsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .has_byte   (out_ch.has_byte),
    .data_byte  (out_ch.data_byte),
    .error_code (out_ch.error_code),
    .text_done  (out_ch.text_done)
  );

endmodule
